>>> design/gbs_pkg.sv
// Shared constants, types and helper functions for the box suppression unit.
`default_nettype none

package gbs_pkg;

    localparam int MAX_BOXES = 64;
    localparam int IDX_W     = $clog2(MAX_BOXES);
    localparam int CNT_W     = $clog2(MAX_BOXES + 1);

    localparam int COORD_W = 16;
    localparam int SCORE_W = 16;
    localparam int THR_W   = 16;
    localparam int SPAN_W  = COORD_W + 1;
    localparam int AREA_W  = 2 * SPAN_W;
    localparam int SUM_W   = AREA_W + 1;
    localparam int PROD_W  = SUM_W + THR_W;

    localparam logic [THR_W-1:0]  THR_RESET = 16'd26214;
    localparam logic [SPAN_W-1:0] ONE_PIXEL = 17'd16;

    // One stored box record
    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] y1;
        logic [COORD_W-1:0] x2;
        logic [COORD_W-1:0] y2;
        logic [AREA_W-1:0]  area;
    } entry_t;

    // Overlap verdict returned to the controller
    typedef struct packed {
        logic             valid;
        logic             hit;
        logic [IDX_W-1:0] idx;
    } hit_t;

    // Inclusive extent, clamped at zero when the edges are inverted
    function automatic logic [SPAN_W-1:0] span(input logic [COORD_W-1:0] lo,
                                               input logic [COORD_W-1:0] hi);
        logic [SPAN_W-1:0] top;
        logic [SPAN_W-1:0] base;
        top  = {1'b0, hi} + ONE_PIXEL;
        base = {1'b0, lo};
        span = (top > base) ? (top - base) : '0;
    endfunction

endpackage

`default_nettype wire

>>> design/gbs_ifs.sv
// Handshake channel interfaces for boxes, kept results and the threshold write.
`default_nettype none

interface gbs_box_if;
    logic                        valid;
    logic                        ready;
    logic [gbs_pkg::SCORE_W-1:0] box_score;
    logic [gbs_pkg::COORD_W-1:0] box_x1;
    logic [gbs_pkg::COORD_W-1:0] box_y1;
    logic [gbs_pkg::COORD_W-1:0] box_x2;
    logic [gbs_pkg::COORD_W-1:0] box_y2;
    logic                        final_box;

    modport source (output valid, box_score, box_x1, box_y1, box_x2, box_y2, final_box,
                    input ready);
    modport sink   (input valid, box_score, box_x1, box_y1, box_x2, box_y2, final_box,
                    output ready);
endinterface

interface gbs_kept_if;
    logic                        valid;
    logic                        ready;
    logic [gbs_pkg::SCORE_W-1:0] kept_score;
    logic [gbs_pkg::COORD_W-1:0] kept_x1;
    logic [gbs_pkg::COORD_W-1:0] kept_y1;
    logic [gbs_pkg::COORD_W-1:0] kept_x2;
    logic [gbs_pkg::COORD_W-1:0] kept_y2;
    logic                        kept_last;
    logic                        batch_overflowed;

    modport source (output valid, kept_score, kept_x1, kept_y1, kept_x2, kept_y2,
                    kept_last, batch_overflowed, input ready);
    modport sink   (input valid, kept_score, kept_x1, kept_y1, kept_x2, kept_y2,
                    kept_last, batch_overflowed, output ready);
endinterface

interface gbs_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [gbs_pkg::THR_W-1:0] overlap_threshold;

    modport source (output valid, overlap_threshold, input ready);
    modport sink   (input valid, overlap_threshold, output ready);
endinterface

`default_nettype wire

>>> design/greedy_box_suppression_unit.sv
// Top level: sorted box loading, greedy suppression sequencer and result output.
//
//  channel   dir   payload                                   word taken when
//  boxes     in    box_score, box_x1..box_y2, final_box      valid & ready
//  kept      out   kept_score, kept_x1..kept_y2, last, ovf   valid & ready
//  cfg       in    overlap_threshold                         valid & ready
//
// Loading a box shifts each stored box of lower score
// one place down, one per cycle through the single memory read port.
// The final box then starts suppression: for each live box i, n - i - 1 streamed
// reads, then the overlap pipeline drains;
// a suppressed box is skipped; each kept word is read, then loaded for output.
// Reset returns to idle with an empty store; kept stalls hold the output word.
`default_nettype none

module greedy_box_suppression_unit (
    input wire logic clk,
    input wire logic rst_n,
    gbs_box_if.sink   boxes,
    gbs_kept_if.source kept,
    gbs_cfg_if.sink   cfg
);
    import gbs_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_AREA = 9'b000000010,
        S_INS  = 9'b000000100,
        S_CMP  = 9'b000001000,
        S_RDI  = 9'b000010000,
        S_LDI  = 9'b000100000,
        S_J    = 9'b001000000,
        S_EMRD = 9'b010000000,
        S_EMWT = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [THR_W-1:0]     thr_reg;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     k_reg, k_next;
    logic [CNT_W-1:0]     i_reg, i_next;
    logic [CNT_W-1:0]     j_reg, j_next;
    logic                 ovf_reg, ovf_next;
    logic [MAX_BOXES-1:0] marks_reg, marks_next;
    logic                 final_reg;
    entry_t               new_reg, new_next;
    entry_t               boxi_reg;
    logic                 rdv_reg, rdv_next;
    logic [IDX_W-1:0]     rdidx_reg;

    logic                 out_valid_reg;
    entry_t               out_reg;
    logic                 out_last_reg, out_ovf_reg;
    logic                 out_load;

    logic                 wr_en, rd_en;
    logic [IDX_W-1:0]     wr_addr, rd_addr;
    entry_t               wr_data, rd_data;
    hit_t                 hit;
    logic                 ov_busy;
    logic [MAX_BOXES-1:0] live;
    logic                 is_last;

    gbs_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    gbs_overlap u_overlap (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rdv_reg),
        .in_idx   (rdidx_reg),
        .box_i    (boxi_reg),
        .box_j    (rd_data),
        .thr      (thr_reg),
        .hit      (hit),
        .busy     (ov_busy)
    );

    assign boxes.ready = (state_reg == S_IDLE);
    assign cfg.ready   = 1'b1;

    // Survivor that has no live survivor after it
    always_comb
    begin
        for (int b = 0; b < MAX_BOXES; b++)
        begin
            live[b] = (CNT_W'(b) < count_reg) && !marks_reg[b];
        end
        is_last = (((live >> i_reg) >> 1) == '0);
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        k_next     = k_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        ovf_next   = ovf_reg;
        marks_next = marks_reg;
        new_next   = new_reg;
        rdv_next   = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = k_reg[IDX_W-1:0];
        wr_data    = new_reg;
        rd_en      = 1'b0;
        rd_addr    = i_reg[IDX_W-1:0];
        out_load   = 1'b0;

        // Record suppression verdicts
        if (hit.valid && hit.hit)
        begin
            marks_next[hit.idx] = 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (boxes.valid)
                begin
                    new_next.score = boxes.box_score;
                    new_next.x1    = boxes.box_x1;
                    new_next.y1    = boxes.box_y1;
                    new_next.x2    = boxes.box_x2;
                    new_next.y2    = boxes.box_y2;
                    state_next     = S_AREA;
                end
            end
            S_AREA:
            begin
                new_next.area = AREA_W'(span(new_reg.x1, new_reg.x2))
                              * AREA_W'(span(new_reg.y1, new_reg.y2));
                k_next        = count_reg;
                i_next        = '0;
                if (count_reg >= CNT_W'(MAX_BOXES))
                begin
                    ovf_next   = 1'b1;
                    state_next = final_reg ? S_RDI : S_IDLE;
                end
                else
                begin
                    state_next = S_INS;
                end
            end
            S_INS:
            begin
                if (k_reg == '0)
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                    state_next = final_reg ? S_RDI : S_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = IDX_W'(k_reg - 1'b1);
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                wr_en = 1'b1;
                if (rd_data.score < new_reg.score)
                begin
                    // Shift the lower score down one place
                    wr_data = rd_data;
                    k_next  = k_reg - 1'b1;
                    if (k_reg > CNT_W'(1))
                    begin
                        rd_en   = 1'b1;
                        rd_addr = IDX_W'(k_reg - CNT_W'(2));
                    end
                    else
                    begin
                        state_next = S_INS;
                    end
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    state_next = final_reg ? S_RDI : S_IDLE;
                end
            end
            S_RDI:
            begin
                if (i_reg >= count_reg)
                begin
                    i_next     = '0;
                    state_next = S_EMRD;
                end
                else if (marks_reg[i_reg[IDX_W-1:0]])
                begin
                    i_next = i_reg + 1'b1;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_LDI;
                end
            end
            S_LDI:
            begin
                j_next     = i_reg + 1'b1;
                state_next = S_J;
            end
            S_J:
            begin
                if (j_reg < count_reg)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = j_reg[IDX_W-1:0];
                    rdv_next = 1'b1;
                    j_next   = j_reg + 1'b1;
                end
                else if (!rdv_reg && !ov_busy)
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_RDI;
                end
            end
            S_EMRD:
            begin
                if (i_reg >= count_reg)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                    marks_next = '0;
                    state_next = S_IDLE;
                end
                else if (marks_reg[i_reg[IDX_W-1:0]])
                begin
                    i_next = i_reg + 1'b1;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_EMWT;
                end
            end
            S_EMWT:
            begin
                if (!out_valid_reg || kept.ready)
                begin
                    out_load   = 1'b1;
                    i_next     = i_reg + 1'b1;
                    state_next = S_EMRD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            thr_reg       <= THR_RESET;
            count_reg     <= '0;
            k_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            ovf_reg       <= 1'b0;
            marks_reg     <= '0;
            rdv_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            k_reg     <= k_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            ovf_reg   <= ovf_next;
            marks_reg <= marks_next;
            rdv_reg   <= rdv_next;
            if (cfg.valid)
            begin
                thr_reg <= cfg.overlap_threshold;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (kept.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        new_reg   <= new_next;
        rdidx_reg <= rd_addr;
        if (state_reg == S_IDLE && boxes.valid)
        begin
            final_reg <= boxes.final_box;
        end
        if (state_reg == S_LDI)
        begin
            boxi_reg <= rd_data;
        end
        if (out_load)
        begin
            out_reg      <= rd_data;
            out_last_reg <= is_last;
            out_ovf_reg  <= ovf_reg;
        end
    end

    // Drive the result word
    assign kept.valid            = out_valid_reg;
    assign kept.kept_score       = out_reg.score;
    assign kept.kept_x1          = out_reg.x1;
    assign kept.kept_y1          = out_reg.y1;
    assign kept.kept_x2          = out_reg.x2;
    assign kept.kept_y2          = out_reg.y2;
    assign kept.kept_last        = out_last_reg;
    assign kept.batch_overflowed = out_ovf_reg;

endmodule

`default_nettype wire

>>> design/gbs_store.sv
// Box record memory: one write port, one registered read port.
`default_nettype none

module gbs_store (
    input  wire logic                      clk,
    input  wire logic                      wr_en,
    input  wire logic [gbs_pkg::IDX_W-1:0] wr_addr,
    input  wire gbs_pkg::entry_t           wr_data,
    input  wire logic                      rd_en,
    input  wire logic [gbs_pkg::IDX_W-1:0] rd_addr,
    output gbs_pkg::entry_t                rd_data
);
    import gbs_pkg::*;

    entry_t mem [MAX_BOXES];
    entry_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> design/gbs_overlap.sv
// Pipelined IoU test of one streamed box against the current leading box.
`default_nettype none

module gbs_overlap (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    input  wire logic [gbs_pkg::IDX_W-1:0] in_idx,
    input  wire gbs_pkg::entry_t           box_i,
    input  wire gbs_pkg::entry_t           box_j,
    input  wire logic [gbs_pkg::THR_W-1:0] thr,
    output gbs_pkg::hit_t                  hit,
    output logic                           busy
);
    import gbs_pkg::*;

    logic              v1_reg, v2_reg, v3_reg;
    logic [IDX_W-1:0]  idx1_reg, idx2_reg, idx3_reg;
    logic [SPAN_W-1:0] w_reg, h_reg;
    logic [SUM_W-1:0]  sum1_reg, sum2_reg;
    logic [AREA_W-1:0] inter2_reg, inter3_reg;
    logic [PROD_W-1:0] prod_reg;

    logic [COORD_W-1:0] lx, ly, rx, ry;
    logic [SUM_W-1:0]   uni;

    // Intersection edges
    always_comb
    begin
        lx = (box_i.x1 > box_j.x1) ? box_i.x1 : box_j.x1;
        ly = (box_i.y1 > box_j.y1) ? box_i.y1 : box_j.y1;
        rx = (box_i.x2 < box_j.x2) ? box_i.x2 : box_j.x2;
        ry = (box_i.y2 < box_j.y2) ? box_i.y2 : box_j.y2;
        uni = sum2_reg - {1'b0, inter2_reg};
    end

    // Advance stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Spans, then intersection product, then threshold product
    always_ff @(posedge clk)
    begin
        idx1_reg   <= in_idx;
        w_reg      <= span(lx, rx);
        h_reg      <= span(ly, ry);
        sum1_reg   <= {1'b0, box_i.area} + {1'b0, box_j.area};
        idx2_reg   <= idx1_reg;
        inter2_reg <= AREA_W'(w_reg) * AREA_W'(h_reg);
        sum2_reg   <= sum1_reg;
        idx3_reg   <= idx2_reg;
        inter3_reg <= inter2_reg;
        prod_reg   <= PROD_W'(thr) * PROD_W'(uni);
    end

    // Compare inter * 2^16 against thr * union
    always_comb
    begin
        hit.valid = v3_reg;
        hit.idx   = idx3_reg;
        hit.hit   = (PROD_W'({inter3_reg, 16'd0}) >= prod_reg);
        busy      = v1_reg | v2_reg | v3_reg;
    end

endmodule

`default_nettype wire

>>> dv/greedy_box_suppression_unit_tb.sv
// Self-checking testbench for the greedy box suppression unit.
`default_nettype none

module greedy_box_suppression_unit_tb;
    import gbs_pkg::*;

    typedef struct packed {
        logic [15:0] score;
        logic [15:0] x1;
        logic [15:0] y1;
        logic [15:0] x2;
        logic [15:0] y2;
        logic        fin;
    } box_t;

    typedef struct packed {
        logic [15:0] score;
        logic [15:0] x1;
        logic [15:0] y1;
        logic [15:0] x2;
        logic [15:0] y2;
        logic        last;
        logic        ovf;
    } kept_t;

    logic clk;
    logic rst_n;
    gbs_box_if  boxes ();
    gbs_kept_if kept ();
    gbs_cfg_if  cfg ();

    greedy_box_suppression_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .boxes (boxes),
        .kept  (kept),
        .cfg   (cfg)
    );

    box_t  pending_boxes[$];
    kept_t expected_kept[$];
    int    errors = 0;
    int    cycle_count = 0;
    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;
    int    cfg_req = 0;
    int    cfg_done = 0;
    logic [15:0] cfg_value = '0;

    // Predictor state
    logic [15:0] thr_model;
    box_t        store_q[$];
    logic        ovf_model;

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [16:0] inc_span(logic [15:0] lo, logic [15:0] hi);
        logic [17:0] top;
        top = {2'b0, hi} + 18'd16;
        return (top > {2'b0, lo}) ? 17'(top - {2'b0, lo}) : 17'd0;
    endfunction

    function automatic logic [33:0] box_area(box_t b);
        return 34'(inc_span(b.x1, b.x2)) * 34'(inc_span(b.y1, b.y2));
    endfunction

    function automatic logic [15:0] max16(logic [15:0] a, logic [15:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [15:0] min16(logic [15:0] a, logic [15:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic bit iou_hit(box_t a, box_t b, logic [15:0] thr);
        logic [33:0] inter;
        logic [34:0] uni;
        logic [63:0] lhs;
        logic [63:0] rhs;
        inter = 34'(inc_span(max16(a.x1, b.x1), min16(a.x2, b.x2)))
              * 34'(inc_span(max16(a.y1, b.y1), min16(a.y2, b.y2)));
        uni = 35'(box_area(a)) + 35'(box_area(b)) - 35'(inter);
        lhs = 64'(inter) << 16;
        rhs = 64'(thr) * 64'(uni);
        return lhs >= rhs;
    endfunction

    // Insert into score-ordered store; suppress and emit on the final box
    task automatic predict_box(box_t b);
        int pos;
        bit gone[64];
        int last_idx;
        kept_t k;
        if (store_q.size() >= MAX_BOXES) begin
            ovf_model = 1'b1;
        end else begin
            pos = store_q.size();
            while (pos > 0 && store_q[pos-1].score < b.score) pos--;
            store_q.insert(pos, b);
        end
        if (b.fin) begin
            foreach (gone[i]) gone[i] = 0;
            for (int i = 0; i < store_q.size(); i++) begin
                if (!gone[i]) begin
                    for (int j = i + 1; j < store_q.size(); j++) begin
                        if (!gone[j] && iou_hit(store_q[i], store_q[j], thr_model))
                            gone[j] = 1;
                    end
                end
            end
            last_idx = -1;
            for (int i = 0; i < store_q.size(); i++) if (!gone[i]) last_idx = i;
            for (int i = 0; i < store_q.size(); i++) begin
                if (!gone[i]) begin
                    k.score = store_q[i].score;
                    k.x1 = store_q[i].x1;
                    k.y1 = store_q[i].y1;
                    k.x2 = store_q[i].x2;
                    k.y2 = store_q[i].y2;
                    k.last = (i == last_idx);
                    k.ovf = ovf_model;
                    expected_kept.insert(expected_kept.size(), k);
                end
            end
            store_q.delete();
            ovf_model = 1'b0;
        end
    endtask

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    // Drive box words from the pending queue
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            boxes.valid <= 1'b0;
        end else begin
            if (boxes.valid && boxes.ready) begin
                predict_box({boxes.box_score, boxes.box_x1, boxes.box_y1,
                             boxes.box_x2, boxes.box_y2, boxes.final_box});
                void'(pending_boxes.pop_front());
            end
            if ((boxes.valid && !boxes.ready) ||
                (pending_boxes.size() > 0 && $urandom_range(99) >= send_idle_pct)) begin
                if (!(boxes.valid && !boxes.ready)) begin
                    automatic box_t nb;
                    nb = pending_boxes[0];
                    boxes.box_score <= nb.score;
                    boxes.box_x1 <= nb.x1;
                    boxes.box_y1 <= nb.y1;
                    boxes.box_x2 <= nb.x2;
                    boxes.box_y2 <= nb.y2;
                    boxes.final_box <= nb.fin;
                end
                boxes.valid <= 1'b1;
            end else begin
                boxes.valid <= 1'b0;
            end
        end
    end

    // Threshold writes, requested by the stimulus only while idle
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg.valid <= 1'b0;
        end else if (cfg.valid && cfg.ready) begin
            thr_model <= cfg.overlap_threshold;
            cfg.valid <= 1'b0;
            cfg_done <= cfg_done + 1;
        end else if (!cfg.valid && cfg_req != cfg_done) begin
            cfg.overlap_threshold <= cfg_value;
            cfg.valid <= 1'b1;
        end
    end

    // Check kept words against the oldest expectation
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            kept.ready <= 1'b0;
        end else begin
            cycle_count <= cycle_count + 1;
            if (kept.valid && kept.ready) begin
                if (expected_kept.size() == 0) begin
                    report_mismatch("unexpected word", kept.kept_score, 16'h0);
                end else begin
                    automatic kept_t w = expected_kept.pop_front();
                    if (kept.kept_score !== w.score)
                        report_mismatch("kept_score", kept.kept_score, w.score);
                    if (kept.kept_x1 !== w.x1) report_mismatch("kept_x1", kept.kept_x1, w.x1);
                    if (kept.kept_y1 !== w.y1) report_mismatch("kept_y1", kept.kept_y1, w.y1);
                    if (kept.kept_x2 !== w.x2) report_mismatch("kept_x2", kept.kept_x2, w.x2);
                    if (kept.kept_y2 !== w.y2) report_mismatch("kept_y2", kept.kept_y2, w.y2);
                    if (kept.kept_last !== w.last)
                        report_mismatch("kept_last", 16'(kept.kept_last), 16'(w.last));
                    if (kept.batch_overflowed !== w.ovf)
                        report_mismatch("batch_overflowed", 16'(kept.batch_overflowed),
                                        16'(w.ovf));
                end
            end
            kept.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Abort on a hung run
    always @(posedge clk) begin
        if (cycle_count > 3000000) begin
            $display("greedy_box_suppression_unit_tb NOT OK");
            $finish;
        end
    end

    function automatic box_t make_box(logic [15:0] s, logic [15:0] x1, logic [15:0] y1,
                                      logic [15:0] x2, logic [15:0] y2, logic fin);
        box_t b;
        b.score = s; b.x1 = x1; b.y1 = y1; b.x2 = x2; b.y2 = y2; b.fin = fin;
        return b;
    endfunction

    // Append one box to the pending queue
    task automatic queue_box(box_t b);
        pending_boxes.insert(pending_boxes.size(), b);
    endtask

    // Box near a cluster center so overlaps are common
    function automatic box_t rand_box(logic fin, bit wide);
        logic [15:0] x;
        logic [15:0] y;
        if (wide || $urandom_range(9) == 0)
            return make_box(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom), fin);
        x = 16'($urandom_range(200, 0) * 64);
        y = 16'($urandom_range(200, 0) * 64);
        x = 16'(x + $urandom_range(255));
        y = 16'(y + $urandom_range(255));
        return make_box(($urandom_range(3) == 0) ? 16'($urandom_range(7) * 8192) : 16'($urandom),
                        x, y, 16'(x + $urandom_range(2047)), 16'(y + $urandom_range(2047)), fin);
    endfunction

    task automatic wait_idle();
        while (pending_boxes.size() != 0 || boxes.valid || expected_kept.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_threshold(logic [15:0] v);
        cfg_value = v;
        cfg_req++;
        while (cfg_done != cfg_req) @(posedge clk);
    endtask

    task automatic random_batches(int items);
        int n;
        int sent;
        sent = 0;
        while (sent < items) begin
            n = ($urandom_range(19) == 0) ? 66 : $urandom_range(12, 1);
            for (int i = 0; i < n; i++)
                queue_box(rand_box(i == n - 1, $urandom_range(7) == 0));
            sent += n;
            while (pending_boxes.size() != 0) @(posedge clk);
        end
    endtask

    initial begin
        rst_n = 1'b0;
        boxes.valid = 1'b0;
        boxes.box_score = '0;
        boxes.box_x1 = '0;
        boxes.box_y1 = '0;
        boxes.box_x2 = '0;
        boxes.box_y2 = '0;
        boxes.final_box = 1'b0;
        kept.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.overlap_threshold = '0;
        thr_model = THR_RESET;
        ovf_model = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset threshold, extremes, ties, inverted edges, zero union
        queue_box(make_box(16'hffff, 16'h0, 16'h0, 16'hffff, 16'hffff, 1'b0));
        queue_box(make_box(16'h0, 16'hffff, 16'hffff, 16'h0, 16'h0, 1'b0));
        queue_box(make_box(16'h8000, 16'h100, 16'h100, 16'h200, 16'h200, 1'b0));
        queue_box(make_box(16'h8000, 16'h110, 16'h100, 16'h210, 16'h200, 1'b0));
        queue_box(make_box(16'h8000, 16'h5000, 16'h5000, 16'h5100, 16'h5100, 1'b0));
        queue_box(make_box(16'h0, 16'hffff, 16'hffff, 16'h0, 16'h0, 1'b1));
        wait_idle();
        queue_box(make_box(16'h1234, 16'h40, 16'h40, 16'h80, 16'h80, 1'b1));
        wait_idle();
        write_threshold(16'h0);
        for (int i = 0; i < 4; i++)
            queue_box(make_box(16'(i * 100), 16'(i * 4096), 16'h0,
                               16'(i * 4096 + 16), 16'h10, i == 3));
        wait_idle();
        write_threshold(16'hffff);
        for (int i = 0; i < 4; i++)
            queue_box(make_box(16'h7777, 16'h200, 16'h200, 16'h300, 16'h300, i == 3));
        wait_idle();

        // Random: three idling phases, threshold changes between
        send_idle_pct = 6;
        recv_idle_pct = 61;
        write_threshold(16'd26214);
        random_batches(110);
        wait_idle();
        send_idle_pct = 61;
        recv_idle_pct = 6;
        write_threshold(16'($urandom));
        random_batches(110);
        wait_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_threshold(16'($urandom_range(40000, 10000)));
        random_batches(100);
        wait_idle();

        if (errors == 0 && expected_kept.size() == 0) begin
            $display("greedy_box_suppression_unit_tb OK");
        end else begin
            $display("greedy_box_suppression_unit_tb NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
